// ===== design/circular_deque_core_assert.svh =====
// assertion macros for the circular deque core
`ifndef CIRCULAR_DEQUE_CORE_ASSERT_SVH
`define CIRCULAR_DEQUE_CORE_ASSERT_SVH

// condition and consequence in the same cycle
`define CDQ_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("deque assertion failed");

// consequence in the cycle after the condition
`define CDQ_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("deque assertion failed");

`endif

// ===== design/cdq_pkg.sv =====
// shared types and constants of the circular deque core
`default_nettype none

package cdq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_W  = 5;
   localparam int WORD_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [1:0] {
      FUNC_PUSH_FRONT = 2'd0,
      FUNC_PUSH_REAR  = 2'd1,
      FUNC_POP_FRONT  = 2'd2,
      FUNC_POP_REAR   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // per-cell write and read select
   typedef struct packed {
      logic wr_en;
      logic rd_sel;
   } cell_ctrl_type;

   // store command from the control logic to the cell row
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [IDX_W-1:0] rd_idx;
   } store_cmd_type;

endpackage

`default_nettype wire

// ===== design/circular_deque_core.sv =====
// circular deque core: index control, cell row and result register
// a result is registered and valid in the cycle after its request transfer
// throughput: one request per cycle; requests wait only while a result is stalled
// the read runs through the row of cells within the cycle of the request
// reset clears indices and the result valid, sets the empty flag and capacity (to 16); words are kept
`default_nettype none

`include "circular_deque_core_assert.svh"

module circular_deque_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // configuration
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [cdq_pkg::CAP_W-1:0]  csr_capacity,
   // requests
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_func,
   input  wire logic signed [cdq_pkg::WORD_W-1:0] req_value,
   // results
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic signed [cdq_pkg::WORD_W-1:0] rsp_data
);
   import cdq_pkg::*;

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic [CAP_W-1:0]  cap_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;

   logic              req_xfer, csr_xfer;
   func_type          func;
   logic [CAP_W-1:0]  cap_used;
   logic [IDX_W-1:0]  cap_last;
   logic [IDX_W-1:0]  head_c, tail_c;
   logic [IDX_W-1:0]  head_up, head_dn, tail_up, tail_dn;
   logic              full;
   store_cmd_type     cmd;
   logic [WORD_W-1:0] rd_data;
   logic              pop_on_empty;
   logic              rsp_refused;
   logic              rsp_empty;

   // handshakes
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign func      = func_type'(req_func);

   // capacity in use, clamped to 1..DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         cap_used = CAP_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         cap_used = CAP_W'(DEPTH);
      end else begin
         cap_used = cap_ff;
      end
   end

   assign cap_last = IDX_W'(cap_used - CAP_W'(1));

   // indices kept inside the capacity in use
   assign head_c = (CAP_W'(head_ff) >= cap_used) ? '0 : head_ff;
   assign tail_c = (CAP_W'(tail_ff) >= cap_used) ? '0 : tail_ff;

   // circular neighbors
   assign head_up = (head_c == cap_last) ? '0 : head_c + IDX_W'(1);
   assign head_dn = (head_c == '0) ? cap_last : head_c - IDX_W'(1);
   assign tail_up = (tail_c == cap_last) ? '0 : tail_c + IDX_W'(1);
   assign tail_dn = (tail_c == '0) ? cap_last : tail_c - IDX_W'(1);

   assign full = !empty_ff && (tail_up == head_c);

   // operation decode, next indices and result
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      rsp_status_in = STATUS_DONE;
      rsp_data_in   = '0;
      cmd.wr_en     = 1'b0;
      cmd.wr_idx    = '0;
      cmd.rd_idx    = head_c;

      unique case (func)
         FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else if (empty_ff) begin
               head_in    = '0;
               tail_in    = '0;
               empty_in   = 1'b0;
               cmd.wr_en  = req_xfer;
               cmd.wr_idx = '0;
            end else if (func == FUNC_PUSH_FRONT) begin
               head_in    = head_dn;
               tail_in    = tail_c;
               cmd.wr_en  = req_xfer;
               cmd.wr_idx = head_dn;
            end else begin
               head_in    = head_c;
               tail_in    = tail_up;
               cmd.wr_en  = req_xfer;
               cmd.wr_idx = tail_up;
            end
         end
         FUNC_POP_FRONT, FUNC_POP_REAR: begin
            cmd.rd_idx = (func == FUNC_POP_FRONT) ? head_c : tail_c;
            if (empty_ff) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_data_in = rd_data;
               if (head_c == tail_c) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else if (func == FUNC_POP_FRONT) begin
                  head_in = head_up;
                  tail_in = tail_c;
               end else begin
                  head_in = head_c;
                  tail_in = tail_dn;
               end
            end
         end
         default: begin
            rsp_status_in = STATUS_DONE;
         end
      endcase
   end

   // result register valid
   always_comb begin
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_xfer) begin
            cap_ff   <= csr_capacity;
            head_ff  <= '0;
            tail_ff  <= '0;
            empty_ff <= 1'b1;
         end else if (req_xfer) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            empty_ff <= empty_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   // row of storage cells
   cdq_chain u_chain (
      .clock   (clock),
      .cmd     (cmd),
      .wr_data ($unsigned(req_value)),
      .rd_data (rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = $signed(rsp_data_ff);

   // terms for the checks
   assign pop_on_empty = req_xfer && !csr_xfer && empty_ff &&
                         ((func == FUNC_POP_FRONT) || (func == FUNC_POP_REAR));
   assign rsp_refused  = rsp_valid_ff && (rsp_status_ff != STATUS_DONE);
   assign rsp_empty    = rsp_valid_ff && (rsp_status_ff == STATUS_EMPTY);

   // checks
   `CDQ_ASSERT_NOW(a_empty_idx, clock, reset, empty_ff, (head_ff == '0) && (tail_ff == '0))
   `CDQ_ASSERT_NOW(a_refused_zero, clock, reset, rsp_refused, rsp_data_ff == '0)
   `CDQ_ASSERT_NEXT(a_pop_empty, clock, reset, pop_on_empty, rsp_empty)

endmodule

`default_nettype wire

// ===== design/cdq_cell.sv =====
// one storage cell of the deque row: holds a word and merges it into the read chain
`default_nettype none

module cdq_cell (
   input  wire logic                       clock,
   input  wire cdq_pkg::cell_ctrl_type     ctrl,
   input  wire logic [cdq_pkg::WORD_W-1:0] wr_data,
   input  wire logic [cdq_pkg::WORD_W-1:0] rd_in,
   output logic      [cdq_pkg::WORD_W-1:0] rd_out
);
   import cdq_pkg::*;

   logic [WORD_W-1:0] word_ff;

   // word storage
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         word_ff <= wr_data;
      end
   end

   // pass the chain on, adding this word when selected
   assign rd_out = rd_in | (ctrl.rd_sel ? word_ff : '0);

endmodule

`default_nettype wire

// ===== design/cdq_chain.sv =====
// row of storage cells with index decode and the read chain
`default_nettype none

module cdq_chain (
   input  wire logic                       clock,
   input  wire cdq_pkg::store_cmd_type     cmd,
   input  wire logic [cdq_pkg::WORD_W-1:0] wr_data,
   output logic      [cdq_pkg::WORD_W-1:0] rd_data
);
   import cdq_pkg::*;

   logic [WORD_W-1:0] link [DEPTH+1];
   cell_ctrl_type     ctrl [DEPTH];

   assign link[0] = '0;

   // one cell per entry, read data handed from cell to cell
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctrl[i].wr_en  = cmd.wr_en && (cmd.wr_idx == IDX_W'(i));
      assign ctrl[i].rd_sel = (cmd.rd_idx == IDX_W'(i));

      cdq_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl[i]),
         .wr_data (wr_data),
         .rd_in   (link[i]),
         .rd_out  (link[i+1])
      );
   end

   assign rd_data = link[DEPTH];

endmodule

`default_nettype wire

// ===== test/circular_deque_core_test.sv =====
`timescale 1ns / 1ps
// testbench for the circular deque core: random deque operations checked against a behavioral deque

module circular_deque_core_test;
   import cdq_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASE_ITEMS = 135;
   localparam int SEGMENT_LEN = 36;

   typedef struct {
      status_type        status;
      logic [WORD_W-1:0] data;
   } deque_result_type;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     csr_valid    = 1'b0;
   logic                     csr_ready;
   logic [CAP_W-1:0]         csr_capacity = CAP_RESET;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_func     = FUNC_PUSH_FRONT;
   logic signed [WORD_W-1:0] req_value    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [WORD_W-1:0] rsp_data;

   // behavioral deque
   logic [WORD_W-1:0] deque_words [DEPTH];
   int unsigned       front_idx;
   int unsigned       rear_idx;
   bit                deque_empty;
   logic [CAP_W-1:0]  capacity_reg;

   deque_result_type pending_results [$];
   int  mismatch_count    = 0;
   int  idle_cycles       = 0;
   int  drain_hold_cycles = 0;
   bit  sender_quiet      = 1'b0;
   bit  drain_quiet       = 1'b0;

   circular_deque_core DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_capacity (csr_capacity),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_deque();
      front_idx   = 0;
      rear_idx    = 0;
      deque_empty = 1'b1;
   endfunction

   // one deque operation on the behavioral deque, returns the expected result
   function automatic deque_result_type apply_deque_op(func_type op, logic [WORD_W-1:0] word);
      deque_result_type res;
      int unsigned      cap;
      res.status = STATUS_DONE;
      res.data   = '0;
      // zero acts as one, anything above the built depth as the depth
      cap = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      if (front_idx >= cap) front_idx = 0;
      if (rear_idx >= cap) rear_idx = 0;
      case (op)
         FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
            if (!deque_empty && (rear_idx + 1) % cap == front_idx) begin
               res.status = STATUS_FULL;
            end else if (deque_empty) begin
               // first word always lands in entry zero
               front_idx      = 0;
               rear_idx       = 0;
               deque_empty    = 1'b0;
               deque_words[0] = word;
            end else if (op == FUNC_PUSH_FRONT) begin
               front_idx = (front_idx == 0) ? cap - 1 : front_idx - 1;
               deque_words[IDX_W'(front_idx)] = word;
            end else begin
               rear_idx = (rear_idx + 1) % cap;
               deque_words[IDX_W'(rear_idx)] = word;
            end
         end
         default: begin
            if (deque_empty) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.data = deque_words[(op == FUNC_POP_FRONT) ? IDX_W'(front_idx) :
                                                               IDX_W'(rear_idx)];
               if (front_idx == rear_idx)
                  clear_deque();
               else if (op == FUNC_POP_FRONT)
                  front_idx = (front_idx + 1) % cap;
               else
                  rear_idx = (rear_idx == 0) ? cap - 1 : rear_idx - 1;
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic func_type random_op(int unsigned push_pct);
      logic rear_end;
      rear_end = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < push_pct)
         return rear_end ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT;
      return rear_end ? FUNC_POP_REAR : FUNC_POP_FRONT;
   endfunction

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      mismatch_count++;
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
   endtask

   // one request transfer, optionally after a random gap
   task automatic send_request(func_type op, logic [WORD_W-1:0] word);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= op;
      req_value <= word;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_deque_op(op, word));
   endtask

   // sender pauses until every expected result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // capacity write, only while the core is idle; it also empties the deque
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_valid    <= 1'b1;
      csr_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      capacity_reg = cap;
      clear_deque();
   endtask

   task automatic test_directed_cases();
      // refused pops right after reset
      send_request(FUNC_POP_FRONT, 32'h1234_5678);
      send_request(FUNC_POP_REAR, '1);
      // single word in and out again
      send_request(FUNC_PUSH_REAR, 32'h7FFF_FFFF);
      send_request(FUNC_POP_FRONT, '0);
      // front index wraps below zero, then pops from the rear down to empty
      send_request(FUNC_PUSH_FRONT, 32'h8000_0000);
      send_request(FUNC_PUSH_FRONT, '1);
      send_request(FUNC_PUSH_REAR, '0);
      send_request(FUNC_POP_REAR, '0);
      send_request(FUNC_POP_REAR, '0);
      send_request(FUNC_POP_REAR, '0);
      send_request(FUNC_POP_FRONT, '0);
      wait_for_results();
      // two-entry deque: refused pushes on both ends when full
      write_capacity(5'd2);
      send_request(FUNC_PUSH_FRONT, 32'h5555_5555);
      send_request(FUNC_PUSH_FRONT, 32'hAAAA_AAAA);
      send_request(FUNC_PUSH_REAR, 32'h0000_0001);
      send_request(FUNC_PUSH_FRONT, 32'h0000_0002);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_PUSH_REAR, 32'h0000_0003);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_POP_REAR, '0);
      wait_for_results();
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      drain_hold_cycles = 60;
      sender_quiet      = 1'b1;
      for (int i = 0; i < 40; i++)
         send_request(random_op(60), random_word());
      sender_quiet = 1'b0;
      wait_for_results();
   endtask

   // fill and drain segments at several capacity settings
   task automatic test_random_phases();
      logic [CAP_W-1:0] settings [10];
      int unsigned      push_pct;
      settings    = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd17, 5'd5, 5'd0, 5'd0, 5'd16};
      settings[7] = CAP_W'($urandom_range(3, 15));
      settings[8] = CAP_W'($urandom_range(18, 30));
      foreach (settings[p]) begin
         wait_for_results();
         write_capacity(settings[p]);
         sender_quiet = (p == 3 || p == 7);
         drain_quiet  = (p == 5 || p == 7);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2)
               wait_for_results();
            push_pct = ((i / SEGMENT_LEN) % 2 == 0) ? 85 : 15;
            send_request(random_op(push_pct), random_word());
         end
      end
      sender_quiet = 1'b0;
      drain_quiet  = 1'b0;
      wait_for_results();
   endtask

   // result side: random stall before each transfer, or a long hold on request
   initial begin : result_drain
      int pause;
      @(posedge clock);
      forever begin
         if (drain_hold_cycles > 0) begin
            pause             = drain_hold_cycles;
            drain_hold_cycles = 0;
         end else begin
            pause = drain_quiet ? 0 : $urandom_range(0, 5);
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : result_check
      deque_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_data, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_data !== want.data)
               report_mismatch("data", rsp_data, want.data);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_deque();
      capacity_reg = CAP_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_backpressure();
      test_random_phases();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
